### rtl/bounded_deque_with_search_top_assert.svh
// assertion macros for the deque top level
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BDQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, checked out of reset
`define BDQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### rtl/bdqs_pkg.sv
`timescale 1ns / 1ps
package bdqs_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

### rtl/bounded_deque_with_search_top.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of 32-bit values with a linear key search, held in a
// single-port-write, single-port-read ring memory of DEPTH entries. Each input beat is
// one operation and yields exactly one result beat carrying status, the 1-based match
// position and the occupancy after the operation. One operation is in flight at a time.
// Push, pop and unused kinds go straight to the done state; a search with entries held
// first scans them from the front, one read per cycle from the memory read port, and
// stops at the first match or after the last held entry, so it reads at most DEPTH
// entries. A search on an empty queue does not scan. In the done state the result is
// loaded into the output register once that is free, and the next beat can be accepted
// after that. The result sits in an output register, so an accepted operation
// completes while the previous result still waits.
module bounded_deque_with_search_top #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((2 * CNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // value[31:0]
    input  logic [2:0]       s_tuser,   // kind[2:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // position, occupancy, zero pad
    output logic [1:0]       m_tuser    // status[1:0]
);

    `include "bounded_deque_with_search_top_assert.svh"

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [bdqs_pkg::VALUE_W-1:0]  ram_wdata;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic [bdqs_pkg::VALUE_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]              position;
    logic [CNT_W-1:0]              occupancy;

    bdqs_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_kind      (s_tuser),
        .s_value     (s_tdata),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_status    (m_tuser),
        .m_position  (position),
        .m_occupancy (occupancy),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    assign m_tdata = OUT_W'({occupancy, position});

    `BDQS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `BDQS_ASSERT_NOW(a_pos_means_found, m_tvalid && (position != '0), m_tuser == bdqs_pkg::STATUS_OK && position <= occupancy)
    `BDQS_ASSERT_NOW(a_full_occ, m_tvalid && (m_tuser == bdqs_pkg::STATUS_FULL), occupancy == CNT_W'(DEPTH))
    `BDQS_ASSERT_NOW(a_empty_occ, m_tvalid && (m_tuser == bdqs_pkg::STATUS_EMPTY), occupancy == '0)

endmodule

### rtl/bdqs_ram.sv
`timescale 1ns / 1ps
module bdqs_ram #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [IDX_W-1:0]              waddr,
    input  logic [bdqs_pkg::VALUE_W-1:0]  wdata,
    input  logic                          re,
    input  logic [IDX_W-1:0]              raddr,
    output logic [bdqs_pkg::VALUE_W-1:0]  rdata
);

    logic [bdqs_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [bdqs_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bdqs_ctrl.sv
`timescale 1ns / 1ps
module bdqs_ctrl #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdqs_pkg::KIND_W-1:0]   s_kind,
    input  logic [bdqs_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bdqs_pkg::STATUS_W-1:0] m_status,
    output logic [CNT_W-1:0]              m_position,
    output logic [CNT_W-1:0]              m_occupancy,
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [bdqs_pkg::VALUE_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [bdqs_pkg::VALUE_W-1:0]  ram_rdata
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    bdqs_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]              front_reg, front_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic [CNT_W-1:0]              issued_reg, issued_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]              cmp_pos_reg, cmp_pos_next;
    logic [bdqs_pkg::VALUE_W-1:0]  key_reg, key_next;
    logic [bdqs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0]              res_pos_reg, res_pos_next;
    logic                          out_vld_reg, out_vld_next;
    logic [bdqs_pkg::STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]              out_pos_reg;
    logic [CNT_W-1:0]              out_occ_reg;

    logic             accept;
    logic             load_out;
    logic             scan_start;
    logic             issue;
    logic             hit;
    logic             scan_end;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;

    assign accept = s_valid && s_ready;
    assign issue  = (state_reg == bdqs_pkg::ST_SCAN) && (issued_reg < count_reg);
    assign hit    = (state_reg == bdqs_pkg::ST_SCAN) && cmp_vld_reg && (ram_rdata == key_reg);
    assign scan_end = (state_reg == bdqs_pkg::ST_SCAN) && !issue;
    assign scan_start = accept && (s_kind == bdqs_pkg::KIND_SEARCH) && (count_reg != '0);

    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM) : IDX_W'(back_sum);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + IDX_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bdqs_pkg::ST_IDLE: begin
                if (scan_start) begin
                    state_next = bdqs_pkg::ST_SCAN;
                end else if (accept) begin
                    state_next = bdqs_pkg::ST_DONE;
                end
            end
            bdqs_pkg::ST_SCAN: begin
                if (hit || scan_end) begin
                    state_next = bdqs_pkg::ST_DONE;
                end
            end
            bdqs_pkg::ST_DONE: begin
                if (!out_vld_reg || m_ready) begin
                    state_next = bdqs_pkg::ST_IDLE;
                end
            end
            default: state_next = bdqs_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            bdqs_pkg::ST_IDLE: s_ready  = 1'b1;
            bdqs_pkg::ST_SCAN: s_ready  = 1'b0;
            bdqs_pkg::ST_DONE: load_out = !out_vld_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // operation datapath
    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        ram_we          = 1'b0;
        ram_waddr       = back_slot;
        ram_wdata       = s_value;
        if (accept) begin
            res_status_next = bdqs_pkg::STATUS_OK;
            res_pos_next    = '0;
            key_next        = s_value;
            unique case (s_kind)
                bdqs_pkg::KIND_PUSH_FRONT: begin
                    if (count_reg == FULL_CNT) begin
                        res_status_next = bdqs_pkg::STATUS_FULL;
                    end else begin
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = front_dec;
                    end
                end
                bdqs_pkg::KIND_PUSH_BACK: begin
                    if (count_reg == FULL_CNT) begin
                        res_status_next = bdqs_pkg::STATUS_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        ram_we     = 1'b1;
                    end
                end
                bdqs_pkg::KIND_POP_FRONT: begin
                    if (count_reg == '0) begin
                        res_status_next = bdqs_pkg::STATUS_EMPTY;
                    end else begin
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdqs_pkg::KIND_POP_BACK: begin
                    if (count_reg == '0) begin
                        res_status_next = bdqs_pkg::STATUS_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdqs_pkg::KIND_SEARCH: begin
                    res_status_next = bdqs_pkg::STATUS_MISS;
                end
                default: begin
                    res_status_next = bdqs_pkg::STATUS_OK;
                end
            endcase
        end else if (hit) begin
            res_status_next = bdqs_pkg::STATUS_OK;
            res_pos_next    = cmp_pos_reg;
        end
    end

    // scan pipeline: issue one read per cycle, compare the previous read
    always_comb begin
        slot_next    = slot_reg;
        issued_next  = issued_reg;
        cmp_vld_next = 1'b0;
        cmp_pos_next = cmp_pos_reg;
        ram_re       = issue;
        ram_raddr    = slot_reg;
        if (scan_start) begin
            slot_next   = front_reg;
            issued_next = '0;
        end else if (issue && !hit) begin
            slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + IDX_W'(1);
            issued_next  = issued_reg + CNT_W'(1);
            cmp_vld_next = 1'b1;
            cmp_pos_next = issued_reg + CNT_W'(1);
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdqs_pkg::ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        issued_reg     <= issued_next;
        cmp_pos_reg    <= cmp_pos_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        if (load_out) begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_occ_reg    <= count_reg;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_status    = out_status_reg;
    assign m_position  = out_pos_reg;
    assign m_occupancy = out_occ_reg;

endmodule

### test/bounded_deque_with_search_top_tb.sv
`timescale 1ns / 1ps
module bounded_deque_with_search_top_tb;

    localparam int KIND_W   = bdqs_pkg::KIND_W;
    localparam int VALUE_W  = bdqs_pkg::VALUE_W;
    localparam int STATUS_W = bdqs_pkg::STATUS_W;
    localparam int DEQ_DEPTH = 16;
    localparam int OUT_W = 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
    localparam int DRAIN_CYCLES = DEQ_DEPTH + 8;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [4:0]          position;
        logic [4:0]          occupancy;
    } outcome_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;   // value[31:0]
    logic [2:0]         s_tuser;   // kind[2:0]
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;   // position[4:0], occupancy[9:5], zero pad
    logic [1:0]         m_tuser;   // status[1:0]

    // shadow copy of the deque
    logic [VALUE_W-1:0] deq_store [DEQ_DEPTH];
    logic [3:0]         deq_front;
    logic [4:0]         deq_count;

    outcome_t pending_results [$];
    int       error_count;
    int       reported_count;
    int       gap_pct;
    int       stall_pct;
    int       hold_cycles;

    bounded_deque_with_search_top #(
        .DEPTH(DEQ_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic outcome_t apply_deque_op(input logic [KIND_W-1:0] kind,
                                                input logic [VALUE_W-1:0] value);
        outcome_t   res;
        logic [3:0] slot;
        int         i;
        res.kind = kind;
        res.value = value;
        res.status = bdqs_pkg::STATUS_OK;
        res.position = '0;
        case (kind)
            bdqs_pkg::KIND_PUSH_FRONT: begin
                if (deq_count == DEQ_DEPTH) begin
                    res.status = bdqs_pkg::STATUS_FULL;
                end else begin
                    deq_front = deq_front - 4'd1;
                    deq_store[deq_front] = value;
                    deq_count = deq_count + 5'd1;
                end
            end
            bdqs_pkg::KIND_PUSH_BACK: begin
                if (deq_count == DEQ_DEPTH) begin
                    res.status = bdqs_pkg::STATUS_FULL;
                end else begin
                    slot = deq_front + deq_count[3:0];
                    deq_store[slot] = value;
                    deq_count = deq_count + 5'd1;
                end
            end
            bdqs_pkg::KIND_POP_FRONT: begin
                if (deq_count == 0) begin
                    res.status = bdqs_pkg::STATUS_EMPTY;
                end else begin
                    deq_front = deq_front + 4'd1;
                    deq_count = deq_count - 5'd1;
                end
            end
            bdqs_pkg::KIND_POP_BACK: begin
                if (deq_count == 0) begin
                    res.status = bdqs_pkg::STATUS_EMPTY;
                end else begin
                    deq_count = deq_count - 5'd1;
                end
            end
            bdqs_pkg::KIND_SEARCH: begin
                res.status = bdqs_pkg::STATUS_MISS;
                for (i = 0; i < int'(deq_count); i++) begin
                    slot = deq_front + i[3:0];
                    if (deq_store[slot] == value) begin
                        res.status = bdqs_pkg::STATUS_OK;
                        res.position = 5'(i + 1);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = deq_count;
        return res;
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_deque_op(kind, value));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return VALUE_W'($urandom_range(0, 7));
        end else if (r < 35) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [VALUE_W-1:0] held_value(input int idx);
        logic [3:0] slot;
        slot = deq_front + idx[3:0];
        return deq_store[slot];
    endfunction

    // receiver: long hold-off when requested, otherwise random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        outcome_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (reported_count < 10) begin
                    $display("unexpected result beat: status %0d position %0d occupancy %0d",
                             m_tuser, m_tdata[4:0], m_tdata[9:5]);
                end
                reported_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tuser !== exp_res.status || m_tdata[4:0] !== exp_res.position
                        || m_tdata[9:5] !== exp_res.occupancy) begin
                    error_count++;
                    if (reported_count < 10) begin
                        $display("mismatch kind %0d value %h: exp %0d %0d %0d, got %0d %0d %0d",
                                 exp_res.kind, exp_res.value, exp_res.status,
                                 exp_res.position, exp_res.occupancy,
                                 m_tuser, m_tdata[4:0], m_tdata[9:5]);
                    end
                    reported_count++;
                end
            end
        end
    end

    task automatic test_basic_ops();
        logic [KIND_W-1:0] k;
        send_op(bdqs_pkg::KIND_POP_FRONT, 32'h0000_0000);
        send_op(bdqs_pkg::KIND_POP_BACK, 32'hffff_ffff);
        send_op(bdqs_pkg::KIND_SEARCH, 32'h0000_0000);
        send_op(bdqs_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
        send_op(bdqs_pkg::KIND_PUSH_BACK, 32'h7fff_ffff);
        send_op(bdqs_pkg::KIND_SEARCH, 32'h7fff_ffff);
        send_op(bdqs_pkg::KIND_SEARCH, 32'h8000_0000);
        send_op(bdqs_pkg::KIND_SEARCH, 32'hffff_ffff);
        for (k = KIND_UNUSED_FIRST; k != bdqs_pkg::KIND_PUSH_FRONT; k++) begin
            send_op(k, $urandom);
        end
        send_op(bdqs_pkg::KIND_POP_BACK, 32'h0000_0000);
        send_op(bdqs_pkg::KIND_POP_FRONT, 32'hffff_ffff);
        send_op(bdqs_pkg::KIND_POP_FRONT, 32'h0000_0000);
    endtask

    // fill past full at both ends, search every third slot, drain past empty
    task automatic test_fill_and_drain();
        int i;
        for (i = 0; i < DEQ_DEPTH + 2; i++) begin
            send_op((i % 2) ? bdqs_pkg::KIND_PUSH_BACK : bdqs_pkg::KIND_PUSH_FRONT,
                    random_value());
        end
        for (i = 0; i < DEQ_DEPTH; i += 3) begin
            send_op(bdqs_pkg::KIND_SEARCH, held_value(i));
        end
        send_op(bdqs_pkg::KIND_SEARCH, held_value(DEQ_DEPTH - 1));
        send_op(bdqs_pkg::KIND_SEARCH, $urandom);
        for (i = 0; i < DEQ_DEPTH + 1; i++) begin
            send_op((i % 2) ? bdqs_pkg::KIND_POP_BACK : bdqs_pkg::KIND_POP_FRONT, $urandom);
        end
    endtask

    task automatic run_random_ops(input int n_ops);
        int                 i;
        int                 r;
        int                 push_span;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        push_span = 24;
        for (i = 0; i < n_ops; i++) begin
            // swing between filling and draining so both ends get hit
            if (i % 48 == 0) push_span = $urandom_range(0, 1) ? 48 : 24;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            end else if (r < 28) begin
                kind = bdqs_pkg::KIND_SEARCH;
            end else if (r < 28 + push_span) begin
                kind = $urandom_range(0, 1) ? bdqs_pkg::KIND_PUSH_BACK
                                            : bdqs_pkg::KIND_PUSH_FRONT;
            end else begin
                kind = $urandom_range(0, 1) ? bdqs_pkg::KIND_POP_BACK
                                            : bdqs_pkg::KIND_POP_FRONT;
            end
            if (kind == bdqs_pkg::KIND_SEARCH && deq_count != 0
                    && $urandom_range(0, 99) < 60) begin
                value = held_value($urandom_range(0, int'(deq_count) - 1));
            end else begin
                value = random_value();
            end
            send_op(kind, value);
        end
    endtask

    task automatic test_output_hold_off();
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 150;
        run_random_ops(30);
        wait_drained();
    endtask

    task automatic test_random_phases();
        gap_pct = 0;
        stall_pct = 0;
        run_random_ops(250);
        wait_drained();
        gap_pct = 77;
        stall_pct = 0;
        run_random_ops(250);
        wait_drained();
        gap_pct = 0;
        stall_pct = 77;
        run_random_ops(250);
        wait_drained();
        gap_pct = 19;
        stall_pct = 19;
        run_random_ops(250);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        deq_front = '0;
        deq_count = '0;
        error_count = 0;
        reported_count = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        wait_drained();
        test_fill_and_drain();
        wait_drained();
        test_output_hold_off();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/bdqs_pkg.sv
rtl/bdqs_ram.sv
rtl/bdqs_ctrl.sv
rtl/bounded_deque_with_search_top.sv
test/bounded_deque_with_search_top_tb.sv
